// ----- rtl/bsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the cubic B-spline segment evaluator.
// No dependencies; every other file in rtl/ imports this package.
package bsp_pkg;

  localparam int FRAC_BITS = 16;

  // register indexes of the configuration port
  localparam logic CFG_PARAM_MIN = 1'b0;
  localparam logic CFG_PARAM_MAX = 1'b1;

  // derivative order codes
  localparam logic [1:0] ORD_POS    = 2'd0;
  localparam logic [1:0] ORD_FIRST  = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;
  localparam logic [1:0] ORD_BAD    = 2'd3;

  // basis function handled by a lane
  localparam logic [1:0] BASIS_0 = 2'd0;
  localparam logic [1:0] BASIS_1 = 2'd1;
  localparam logic [1:0] BASIS_2 = 2'd2;
  localparam logic [1:0] BASIS_3 = 2'd3;

  localparam logic signed [17:0] PARAM_MIN_RST = 18'sd0;
  localparam logic signed [17:0] PARAM_MAX_RST = 18'sd65536;

  // floor(2^32 / 3), truncated reciprocal for the divide by three
  localparam logic [30:0] RECIP3  = 31'd1431655765;
  // bias that keeps the dividend of the divide by three positive
  localparam logic [25:0] DIV_OFS = 26'd8388608;

  localparam logic signed [35:0] OUT_HI = 36'sh7_FFFF_FFFF;
  localparam logic signed [35:0] OUT_LO = 36'sh8_0000_0000;

  typedef struct packed {
    logic signed [17:0] u;
    logic signed [19:0] t2;
    logic signed [21:0] t3;
  } pw_t;

  typedef struct packed {
    logic signed [53:0] pos;
    logic signed [53:0] d1;
    logic signed [53:0] d2;
  } lane_out_t;

  typedef struct packed {
    logic       vld;
    logic       err;
    logic [1:0] order;
  } meta_t;

endpackage

// ----- rtl/bsp_powers.sv -----
`timescale 1ns / 1ps
// Power unit: rounded u^2 / S and u^3 / S^2 over three pipeline stages.
// Depends on bsp_pkg.
module bsp_powers (
  input  logic                 clk_i,
  input  logic signed [17:0]   u_i,
  output bsp_pkg::pw_t         pw_o
);
  import bsp_pkg::*;

  localparam logic signed [35:0] RND_T2 = 36'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [53:0] RND_T3 = 54'sd1 <<< (2 * FRAC_BITS - 1);

  logic signed [35:0] uu_d, uu_q;
  logic signed [17:0] u1_q, u2_q;
  logic signed [53:0] uuu_d, uuu_q;
  logic signed [35:0] t2s;
  logic signed [19:0] t2_d, t2_q;
  logic signed [53:0] t3s;
  pw_t                pw_d, pw_q;

  assign uu_d  = u_i * u_i;
  assign uuu_d = uu_q * u1_q;
  assign t2s   = (uu_q + RND_T2) >>> FRAC_BITS;
  assign t2_d  = t2s[19:0];
  assign t3s   = (uuu_q + RND_T3) >>> (2 * FRAC_BITS);

  always_comb begin
    pw_d.u  = u2_q;
    pw_d.t2 = t2_q;
    pw_d.t3 = t3s[21:0];
  end

  always_ff @(posedge clk_i) begin
    uu_q  <= uu_d;
    u1_q  <= u_i;
    uuu_q <= uuu_d;
    t2_q  <= t2_d;
    u2_q  <= u1_q;
    pw_q  <= pw_d;
  end

  assign pw_o = pw_q;

endmodule

// ----- rtl/bsp_lane.sv -----
`timescale 1ns / 1ps
// One basis lane: weights of one basis function and their products with
// its control coordinate, five pipeline stages. Depends on bsp_pkg.
module bsp_lane (
  input  logic                  clk_i,
  input  logic [1:0]            lane_idx_i,
  input  bsp_pkg::pw_t          pw_i,
  input  logic signed [31:0]    c_i,
  output bsp_pkg::lane_out_t    lo_o
);
  import bsp_pkg::*;

  localparam logic signed [23:0] S1 = 24'sd1 <<< FRAC_BITS;
  localparam logic signed [23:0] S2 = 24'sd1 <<< (FRAC_BITS + 1);
  localparam logic signed [23:0] S4 = 24'sd1 <<< (FRAC_BITS + 2);

  logic signed [23:0] ux, t2x, t3x;
  logic signed [23:0] nw_d, nd_d, ne_d;
  logic signed [23:0] nw_q, nd_q, ne_q;
  logic signed [31:0] c1_q, c2_q, c3_q, c4_q;

  logic signed [25:0] y, z, zb;
  logic [24:0]        zp_d, zp_q, zp3_q;
  logic signed [23:0] dr;
  logic signed [21:0] d_q, d3_q, d4_q, e_q, e3_q, e4_q;

  logic [55:0]        rp_d, rp_q;
  logic [23:0]        q0;
  logic [25:0]        rem;
  logic [23:0]        q;
  logic [25:0]        wq;
  logic signed [21:0] w_q;

  lane_out_t          lo_d, lo_q;

  assign ux  = 24'(pw_i.u);
  assign t2x = 24'(pw_i.t2);
  assign t3x = 24'(pw_i.t3);

  // numerators of the position, slope and curvature weights
  always_comb begin
    case (lane_idx_i)
      BASIS_0: begin
        nw_d = S1 - (ux + (ux <<< 1)) + (t2x + (t2x <<< 1)) - t3x;
        nd_d = (ux <<< 1) - S1 - t2x;
        ne_d = S1 - ux;
      end
      BASIS_1: begin
        nw_d = (t3x + (t3x <<< 1)) - ((t2x <<< 1) + (t2x <<< 2)) + S4;
        nd_d = (t2x + (t2x <<< 1)) - (ux <<< 2);
        ne_d = (ux + (ux <<< 1)) - S2;
      end
      BASIS_2: begin
        nw_d = (t2x + (t2x <<< 1)) - (t3x + (t3x <<< 1)) + (ux + (ux <<< 1)) + S1;
        nd_d = (ux <<< 1) + S1 - (t2x + (t2x <<< 1));
        ne_d = S1 - (ux + (ux <<< 1));
      end
      default: begin
        nw_d = t3x;
        nd_d = t2x;
        ne_d = ux;
      end
    endcase
  end

  // round(n / 6) = floor(floor((2n + 6) / 4) / 3), biased positive
  assign y    = (26'(nw_q) <<< 1) + 26'sd6;
  assign z    = y >>> 2;
  assign zb   = z + $signed(DIV_OFS + (DIV_OFS << 1));
  assign zp_d = zb[24:0];
  assign dr   = (nd_q + 24'sd1) >>> 1;

  assign rp_d = zp_q * RECIP3;

  // estimate is low by at most one: fix with one compare
  assign q0  = rp_q[55:32];
  assign rem = 26'(zp3_q) - (26'(q0) + (26'(q0) << 1));
  assign q   = (rem >= 26'd3) ? q0 + 24'd1 : q0;
  assign wq  = 26'(q) - DIV_OFS;

  always_comb begin
    lo_d.pos = c4_q * w_q;
    lo_d.d1  = c4_q * d4_q;
    lo_d.d2  = c4_q * e4_q;
  end

  always_ff @(posedge clk_i) begin
    nw_q  <= nw_d;
    nd_q  <= nd_d;
    ne_q  <= ne_d;
    c1_q  <= c_i;

    zp_q  <= zp_d;
    d_q   <= dr[21:0];
    e_q   <= ne_q[21:0];
    c2_q  <= c1_q;

    rp_q  <= rp_d;
    zp3_q <= zp_q;
    d3_q  <= d_q;
    e3_q  <= e_q;
    c3_q  <= c2_q;

    w_q   <= wq[21:0];
    d4_q  <= d3_q;
    e4_q  <= e3_q;
    c4_q  <= c3_q;

    lo_q  <= lo_d;
  end

  assign lo_o = lo_q;

endmodule

// ----- rtl/bsp_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: adds the four lane products, rounds, saturates and applies
// the order and error masks; two stages. Depends on bsp_pkg.
module bsp_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsp_pkg::lane_out_t   lane_i [4],
  input  bsp_pkg::meta_t       meta_i,
  output logic                 done_o,
  output logic signed [35:0]   position_o,
  output logic signed [35:0]   first_deriv_o,
  output logic signed [35:0]   second_deriv_o,
  output logic                 error_o
);
  import bsp_pkg::*;

  localparam logic signed [55:0] RND = 56'sd1 <<< (FRAC_BITS - 1);

  function automatic logic signed [35:0] rnd_sat(input logic signed [55:0] s);
    logic signed [55:0] r;
    r = (s + RND) >>> FRAC_BITS;
    if (r > 56'(OUT_HI)) begin
      return OUT_HI;
    end else if (r < 56'(OUT_LO)) begin
      return OUT_LO;
    end
    return r[35:0];
  endfunction

  logic signed [54:0] p01_q, p23_q, a01_q, a23_q, b01_q, b23_q;
  meta_t              meta1_q;
  logic signed [55:0] pos_sum, d1_sum, d2_sum;
  logic signed [35:0] pos_d, d1_d, d2_d;
  logic signed [35:0] pos_q, d1_q, d2_q;
  logic               done_q, err_q;
  logic               keep_d1, keep_d2;

  assign pos_sum = 56'(p01_q) + 56'(p23_q);
  assign d1_sum  = 56'(a01_q) + 56'(a23_q);
  assign d2_sum  = 56'(b01_q) + 56'(b23_q);

  assign keep_d1 = !meta1_q.err && (meta1_q.order != ORD_POS);
  assign keep_d2 = !meta1_q.err && (meta1_q.order == ORD_SECOND);

  assign pos_d = meta1_q.err ? 36'sd0 : rnd_sat(pos_sum);
  assign d1_d  = keep_d1 ? rnd_sat(d1_sum) : 36'sd0;
  assign d2_d  = keep_d2 ? rnd_sat(d2_sum) : 36'sd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      done_q  <= 1'b0;
    end else begin
      meta1_q <= meta_i;
      done_q  <= meta1_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p01_q <= 55'(lane_i[0].pos) + 55'(lane_i[1].pos);
    p23_q <= 55'(lane_i[2].pos) + 55'(lane_i[3].pos);
    a01_q <= 55'(lane_i[0].d1) + 55'(lane_i[1].d1);
    a23_q <= 55'(lane_i[2].d1) + 55'(lane_i[3].d1);
    b01_q <= 55'(lane_i[0].d2) + 55'(lane_i[1].d2);
    b23_q <= 55'(lane_i[2].d2) + 55'(lane_i[3].d2);
    pos_q <= pos_d;
    d1_q  <= d1_d;
    d2_q  <= d2_d;
    err_q <= meta1_q.err;
  end

  assign done_o         = done_q;
  assign position_o     = pos_q;
  assign first_deriv_o  = d1_q;
  assign second_deriv_o = d2_q;
  assign error_o        = err_q;

endmodule

// ----- rtl/cubic_bspline_segment_eval_unit.sv -----
`timescale 1ns / 1ps
// Uniform cubic B-spline segment evaluator, one coordinate per word.
// done_o rises once an accepted word has passed every stage listed below.
// Throughput: one word per cycle; busy_o stays low, the pipeline never stalls.
// After the entry stage come the power unit (3), the lane weight and product chain
// (5, with the divide by six as a reciprocal multiply) and the merge adders (2).
// Reset: rst_ni clears valid bits and loads param_min = 0, param_max = 1.0.
module cubic_bspline_segment_eval_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command side
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [31:0]   ctrl_coord0_i,
  input  logic signed [31:0]   ctrl_coord1_i,
  input  logic signed [31:0]   ctrl_coord2_i,
  input  logic signed [31:0]   ctrl_coord3_i,
  input  logic signed [17:0]   param_u_i,
  input  logic [1:0]           max_order_i,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [17:0]          cfg_wdata_i,
  // result side, one-cycle strobe
  output logic                 done_o,
  output logic signed [35:0]   position_o,
  output logic signed [35:0]   first_deriv_o,
  output logic signed [35:0]   second_deriv_o,
  output logic                 error_o
);
  import bsp_pkg::*;

  localparam int CDLY = 4;   // coordinate line: entry stage plus power unit depth
  localparam int MDLY = 9;   // word meta line: entry stage plus power unit and lanes

  logic signed [17:0] pmin_q, pmin_d, pmax_q, pmax_d;
  logic               accept;
  logic               err_in;
  logic signed [17:0] u0_q;
  logic signed [31:0] c_q [CDLY][4];
  meta_t              meta_q [MDLY];
  meta_t              meta_d;
  pw_t                pw;
  lane_out_t          lane_out [4];

  // the pipeline never stalls, so a word is taken on every start
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // configuration registers: take any write, ignore nothing else
  always_comb begin
    pmin_d = pmin_q;
    pmax_d = pmax_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PARAM_MIN: pmin_d = cfg_wdata_i;
        CFG_PARAM_MAX: pmax_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q <= PARAM_MIN_RST;
      pmax_q <= PARAM_MAX_RST;
    end else begin
      pmin_q <= pmin_d;
      pmax_q <= pmax_d;
    end
  end

  // range and order check at entry; an empty range flags every word
  assign err_in = (param_u_i < pmin_q) || (param_u_i > pmax_q) ||
                  (max_order_i == ORD_BAD);

  always_comb begin
    meta_d.vld   = accept;
    meta_d.err   = err_in;
    meta_d.order = max_order_i;
  end

  // meta line: valid, error and order advance with the word; reset clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MDLY; i++) begin
        meta_q[i] <= '0;
      end
    end else begin
      meta_q[0] <= meta_d;
      for (int i = 1; i < MDLY; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // entry registers and the coordinate delay line that keeps the
  // coordinates in step with the power unit
  always_ff @(posedge clk_i) begin
    u0_q       <= param_u_i;
    c_q[0][0]  <= ctrl_coord0_i;
    c_q[0][1]  <= ctrl_coord1_i;
    c_q[0][2]  <= ctrl_coord2_i;
    c_q[0][3]  <= ctrl_coord3_i;
    for (int i = 1; i < CDLY; i++) begin
      for (int j = 0; j < 4; j++) begin
        c_q[i][j] <= c_q[i-1][j];
      end
    end
  end

  bsp_powers u_powers (
    .clk_i (clk_i),
    .u_i   (u0_q),
    .pw_o  (pw)
  );

  // one lane per basis function
  bsp_lane u_lane0 (
    .clk_i      (clk_i),
    .lane_idx_i (BASIS_0),
    .pw_i       (pw),
    .c_i        (c_q[CDLY-1][0]),
    .lo_o       (lane_out[0])
  );

  bsp_lane u_lane1 (
    .clk_i      (clk_i),
    .lane_idx_i (BASIS_1),
    .pw_i       (pw),
    .c_i        (c_q[CDLY-1][1]),
    .lo_o       (lane_out[1])
  );

  bsp_lane u_lane2 (
    .clk_i      (clk_i),
    .lane_idx_i (BASIS_2),
    .pw_i       (pw),
    .c_i        (c_q[CDLY-1][2]),
    .lo_o       (lane_out[2])
  );

  bsp_lane u_lane3 (
    .clk_i      (clk_i),
    .lane_idx_i (BASIS_3),
    .pw_i       (pw),
    .c_i        (c_q[CDLY-1][3]),
    .lo_o       (lane_out[3])
  );

  // sum the lanes, round, saturate, mask unrequested derivatives and error words
  bsp_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lane_i         (lane_out),
    .meta_i         (meta_q[MDLY-1]),
    .done_o         (done_o),
    .position_o     (position_o),
    .first_deriv_o  (first_deriv_o),
    .second_deriv_o (second_deriv_o),
    .error_o        (error_o)
  );

endmodule
